// File: hdl/prq_pkg.sv
package prq_pkg;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  localparam logic [30:0] POS_SCALE_RESET = 31'd1073741824;
  localparam logic signed [5:0] IDENTITY_SHIFT_RESET = 6'sd0;

  localparam logic REG_POS_SCALE = 1'b0;
  localparam logic REG_IDENTITY_SHIFT = 1'b1;

  typedef struct packed {
    logic signed [31:0] operand;
    logic [30:0] multiplier;
    logic signed [5:0] shift;
  } item_t;

endpackage

// File: hdl/prq_queue.sv
module prq_queue #(
  parameter int WIDTH = 16,
  parameter int DEPTH = prq_pkg::MID_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

// File: hdl/prq_front.sv
module prq_front (
  input  logic signed [15:0] input_value,
  input  logic signed [15:0] alpha_value,
  input  logic [30:0]        alpha_scale,
  input  logic signed [5:0]  alpha_shift,
  input  logic [30:0]        pos_scale,
  input  logic signed [5:0]  identity_shift,
  output prq_pkg::item_t     item
);

  logic signed [31:0] scaled;

  assign scaled = 32'(input_value) * 32'(alpha_value);

  always_comb begin
    if (input_value[15]) begin
      item.operand = scaled;
      item.multiplier = alpha_scale;
      item.shift = alpha_shift;
    end else begin
      item.operand = {{16{input_value[15]}}, input_value};
      item.multiplier = pos_scale;
      item.shift = identity_shift;
    end
  end

endmodule

// File: hdl/prq_back.sv
module prq_back #(
  parameter int OUT_DEPTH = prq_pkg::OUT_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  prq_pkg::item_t     item,
  input  logic               item_valid,
  output logic               item_pop,
  input  logic               res_take,
  output logic               res_push,
  output logic signed [15:0] res_value
);

  localparam int CW = $clog2(OUT_DEPTH + 1);

  logic [CW-1:0] credits;
  logic [CW-1:0] credits_next;

  logic [4:0] ls;
  logic [4:0] rs;
  logic signed [6:0] neg_shift;

  logic v0;
  logic v1;
  logic v2;
  logic signed [31:0] a0;
  logic [30:0] b0;
  logic [4:0] rs0;
  logic signed [63:0] ab1;
  logic [4:0] rs1;
  logic signed [31:0] h2;
  logic [4:0] rs2;

  logic signed [63:0] nudge;
  logic signed [63:0] sum;
  logic signed [31:0] h;
  logic signed [31:0] fl;
  logic [31:0] mask;
  logic [31:0] rem;
  logic [31:0] thr;
  logic signed [32:0] r;
  logic signed [15:0] clamped;

  assign item_pop = item_valid && (credits != '0);
  assign credits_next = credits + CW'(res_take) - CW'(item_pop);

  assign neg_shift = -{item.shift[5], item.shift};
  assign ls = (item.shift > 6'sd0) ? item.shift[4:0] : 5'd0;
  assign rs = (item.shift > 6'sd0) ? 5'd0 : (neg_shift[5] ? 5'd31 : neg_shift[4:0]);

  assign nudge = ab1[63] ? (64'sd1 - 64'sd1073741824) : 64'sd1073741824;
  assign sum = ab1 + nudge;
  assign h = sum[62:31] + 32'(ab1[63] && (sum[30:0] != '0));

  assign fl = h2 >>> rs2;
  assign mask = (32'd1 << rs2) - 32'd1;
  assign rem = h2 & mask;
  assign thr = (mask >> 1) + 32'(h2[31]);
  assign r = {fl[31], fl} + 33'(rem > thr);

  always_comb begin
    priority if (r > 33'sd32767) begin
      clamped = 16'sh7fff;
    end else if (r < -33'sd32768) begin
      clamped = -16'sh8000;
    end else begin
      clamped = r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    a0 <= item.operand << ls;
    b0 <= item.multiplier;
    rs0 <= rs;
    ab1 <= 64'(a0) * 64'($signed({1'b0, b0}));
    rs1 <= rs0;
    h2 <= h;
    rs2 <= rs1;
    res_value <= clamped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= CW'(OUT_DEPTH);
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      res_push <= 1'b0;
    end else begin
      credits <= credits_next;
      v0 <= item_pop;
      v1 <= v0;
      v2 <= v1;
      res_push <= v2;
    end
  end

endmodule

// File: hdl/prelu_int16_requantize_unit.sv
// Channel   Handshake              Beat
// input     push / full            input_value, alpha_value, alpha_scale, alpha_shift
// result    pop / empty            output_value
// config    psel, penable, pready  pos_scale at 0x0, identity_shift at 0x4
//
// One beat per cycle is sustained in both directions while the result side keeps popping.
// A result passes in order through the input queue, the four-stage scaling pipeline and the result queue.
// Reset is synchronous and empties both queues and the pipeline.
// A stalled result side fills the result queue, then the input queue, and then raises full.
module prelu_int16_requantize_unit #(
  parameter int MID_DEPTH = prq_pkg::MID_DEPTH,
  parameter int OUT_DEPTH = prq_pkg::OUT_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] input_value,
  input  logic signed [15:0] alpha_value,
  input  logic [30:0]        alpha_scale,
  input  logic signed [5:0]  alpha_shift,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] output_value,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int ITEM_W = $bits(prq_pkg::item_t);

  logic [30:0] pos_scale;
  logic signed [5:0] identity_shift;
  logic cfg_write;

  prq_pkg::item_t front_item;
  logic [ITEM_W-1:0] mid_data;
  logic mid_empty;
  logic mid_push;
  logic item_pop;
  logic res_push;
  logic res_take;
  logic out_full;
  logic signed [15:0] res_value;
  logic [15:0] out_data;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_scale <= prq_pkg::POS_SCALE_RESET;
      identity_shift <= prq_pkg::IDENTITY_SHIFT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        prq_pkg::REG_POS_SCALE: pos_scale <= pwdata[30:0];
        prq_pkg::REG_IDENTITY_SHIFT: identity_shift <= pwdata[5:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      prq_pkg::REG_POS_SCALE: prdata = {1'b0, pos_scale};
      prq_pkg::REG_IDENTITY_SHIFT: prdata = {{26{identity_shift[5]}}, identity_shift};
    endcase
  end

  prq_front u_front (
    .input_value    (input_value),
    .alpha_value    (alpha_value),
    .alpha_scale    (alpha_scale),
    .alpha_shift    (alpha_shift),
    .pos_scale      (pos_scale),
    .identity_shift (identity_shift),
    .item           (front_item)
  );

  assign mid_push = push && !full;

  prq_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (mid_push),
    .push_data (front_item),
    .full      (full),
    .pop       (item_pop),
    .pop_data  (mid_data),
    .empty     (mid_empty)
  );

  prq_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (prq_pkg::item_t'(mid_data)),
    .item_valid (!mid_empty),
    .item_pop   (item_pop),
    .res_take   (res_take),
    .res_push   (res_push),
    .res_value  (res_value)
  );

  assign res_take = pop && !empty;

  prq_queue #(
    .WIDTH (16),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_value),
    .full      (out_full),
    .pop       (res_take),
    .pop_data  (out_data),
    .empty     (empty)
  );

  assign output_value = $signed(out_data);

  assert property (@(posedge clk) disable iff (rst) !(res_push && out_full && !res_take))
    else $error("Result written into a full result queue.");

  assert property (@(posedge clk) disable iff (rst) (push && !full) |=> !mid_empty)
    else $error("Accepted beat did not reach the input queue.");

  assert property (@(posedge clk) disable iff (rst) item_pop |-> !mid_empty)
    else $error("Scaling pipeline took an item from an empty input queue.");

endmodule

// File: sim/prelu_output_checker.sv
module prelu_output_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic signed [15:0] input_value,
  input  logic signed [15:0] alpha_value,
  input  logic [30:0]        alpha_scale,
  input  logic signed [5:0]  alpha_shift,
  input  logic               empty,
  input  logic               pop,
  input  logic signed [15:0] output_value,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 mismatch_count,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [30:0]        pos_scale;
  logic signed [5:0]  identity_shift;
  logic signed [15:0] expected_outputs[$];
  int                 mismatches;

  function automatic longint scale_by_multiplier(longint operand, logic [30:0] mult,
                                                 logic signed [5:0] shift);
    int          shift_amount;
    int unsigned left_amount;
    int unsigned right_amount;
    logic [31:0] wrapped;
    longint      a;
    longint      b;
    longint      product;
    longint      nudge;
    longint      high;
    longint      floored;
    longint      remainder;
    longint      threshold;
    shift_amount = shift;
    left_amount = (shift_amount > 0) ? shift_amount : 0;
    right_amount = (shift_amount > 0) ? 0 : -shift_amount;
    if (right_amount > 31) begin
      right_amount = 31;
    end
    wrapped = operand[31:0] << left_amount;
    a = $signed(wrapped);
    b = {33'd0, mult};
    product = a * b;
    nudge = (product >= 0) ? 64'sd1073741824 : -64'sd1073741823;
    high = (product + nudge) / 64'sd2147483648;
    floored = high >>> right_amount;
    remainder = high - (floored <<< right_amount);
    threshold = (((64'sd1 <<< right_amount) - 1) >>> 1) + ((high < 0) ? 1 : 0);
    return floored + ((remainder > threshold) ? 1 : 0);
  endfunction

  function automatic logic signed [15:0] prelu_requantize(logic signed [15:0] x,
                                                          logic signed [15:0] alpha,
                                                          logic [30:0] mult,
                                                          logic signed [5:0] shift);
    longint scaled;
    longint x_wide;
    longint alpha_wide;
    x_wide = x;
    alpha_wide = alpha;
    if (x_wide >= 0) begin
      scaled = scale_by_multiplier(x_wide, pos_scale, identity_shift);
    end else begin
      scaled = scale_by_multiplier(x_wide * alpha_wide, mult, shift);
    end
    if (scaled > 32767) begin
      scaled = 32767;
    end
    if (scaled < -32768) begin
      scaled = -32768;
    end
    return scaled[15:0];
  endfunction

  always @(posedge clk) begin
    logic signed [15:0] expected;
    if (rst) begin
      expected_outputs.delete();
      pos_scale = prq_pkg::POS_SCALE_RESET;
      identity_shift = prq_pkg::IDENTITY_SHIFT_RESET;
    end else begin
      if (pop && !empty) begin
        if (expected_outputs.size() == 0) begin
          mismatches++;
          $display("%0t: output beat %0d with no expected value", $time, output_value);
        end else begin
          expected = expected_outputs.pop_front();
          if (output_value !== expected) begin
            mismatches++;
            $display("%0t: output_value mismatch, expected %0d, got %0d", $time, expected,
                     output_value);
          end
        end
      end
      if (push && !full) begin
        expected_outputs.push_back(prelu_requantize(input_value, alpha_value,
                                                    alpha_scale, alpha_shift));
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == prq_pkg::REG_POS_SCALE) begin
          pos_scale = pwdata[30:0];
        end else if (paddr[2] == prq_pkg::REG_IDENTITY_SHIFT) begin
          identity_shift = pwdata[5:0];
        end
      end
    end
    mismatch_count <= mismatches;
    outstanding <= expected_outputs.size();
  end

endmodule

// File: sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 6;
  localparam int BEATS_PER_PHASE = 142;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic signed [15:0] input_value = '0;
  logic signed [15:0] alpha_value = '0;
  logic [30:0]        alpha_scale = '0;
  logic signed [5:0]  alpha_shift = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [15:0] output_value;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  int                 mismatch_count;
  int                 outstanding;
  logic               steady = 1'b0;
  int                 cycle_count = 0;

  prelu_int16_requantize_unit dut (.*);

  prelu_output_checker watch (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    pop <= steady || ($urandom_range(99) >= 26);
  end

  task automatic send_beat(logic signed [15:0] x, logic signed [15:0] alpha,
                           logic [30:0] mult, logic signed [5:0] shift);
    while (!steady && $urandom_range(99) < 26) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    input_value <= x;
    alpha_value <= alpha;
    alpha_scale <= mult;
    alpha_shift <= shift;
    do @(posedge clk); while (full);
  endtask

  task automatic send_random_beat();
    logic signed [15:0] x;
    logic signed [15:0] alpha;
    logic [30:0]        mult;
    int                 shift_choice;
    case ($urandom_range(9))
      0: x = 16'sd0;
      1: x = 16'sh7FFF;
      2: x = 16'sh8000;
      3, 4, 5: x = -16'($urandom_range(1, 300));
      default: x = 16'($urandom);
    endcase
    alpha = ($urandom_range(2) == 0) ? 16'($urandom) : 16'(int'($urandom_range(512)) - 256);
    mult = ($urandom_range(3) == 0) ? 31'($urandom)
                                    : 31'($urandom_range(32'h7FFFFFFF, 32'h40000000));
    shift_choice = ($urandom_range(3) == 0) ? int'($urandom_range(63))
                                            : int'($urandom_range(26)) - 22;
    send_beat(x, alpha, mult, shift_choice[5:0]);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(logic index, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [30:0]       phase_mult[PHASES];
    logic signed [5:0] phase_shift[PHASES];
    int                shift_pick;
    phase_mult = '{prq_pkg::POS_SCALE_RESET, 31'h7FFFFFFF, 31'd0, 31'd0, 31'd0,
                   31'h7FFFFFFF};
    phase_shift = '{prq_pkg::IDENTITY_SHIFT_RESET, 6'sd31, 6'b100000, 6'sd0, 6'sd0, -6'sd31};
    phase_mult[3] = 31'($urandom_range(32'h7FFFFFFF, 32'h40000000));
    shift_pick = int'($urandom_range(18)) - 16;
    phase_shift[3] = shift_pick[5:0];
    phase_mult[4] = 31'($urandom);
    shift_pick = int'($urandom_range(1, 5));
    phase_shift[4] = shift_pick[5:0];

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_beat(16'sd0, 16'sd5, 31'h40000000, 6'sd0);
    send_beat(16'sh7FFF, 16'sd0, 31'd0, 6'sd0);
    send_beat(16'sd1, 16'sd0, 31'd0, 6'sd0);
    send_beat(-16'sd1, 16'sd1, 31'h40000000, 6'sd0);
    send_beat(-16'sd1, -16'sd1, 31'h40000000, 6'sd0);
    send_beat(16'sh8000, 16'sh8000, 31'h7FFFFFFF, 6'sd0);
    send_beat(16'sh8000, 16'sh7FFF, 31'h7FFFFFFF, 6'sd0);
    send_beat(16'sh8000, 16'sh8000, 31'h40000000, 6'sd30);
    send_beat(-16'sd3, 16'sd7, 31'h7FFFFFFF, 6'sd31);
    send_beat(16'sh8000, 16'sh7FFF, 31'h7FFFFFFF, -6'sd31);
    send_beat(16'sh8000, 16'sh8000, 31'h7FFFFFFF, 6'b100000);
    send_beat(-16'sd5, 16'sd3, 31'h40000000, -6'sd1);
    send_beat(-16'sd3, 16'sd1, 31'h7FFFFFFF, -6'sd2);
    send_beat(-16'sd1, 16'sh7FFF, 31'd0, 6'sd0);
    send_beat(-16'sd100, 16'sd0, 31'h40000000, 6'sd0);
    send_beat(16'sh8000, 16'sd1, 31'h55555555, -6'sd15);
    send_beat(-16'sd1, 16'sh8000, 31'h7FFFFFFF, -6'sd15);
    send_beat(16'sh4000, 16'sd0, 31'h2AAAAAAA, 6'sd5);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      write_register(prq_pkg::REG_POS_SCALE, {1'b0, phase_mult[phase]});
      write_register(prq_pkg::REG_IDENTITY_SHIFT,
                     {{26{phase_shift[phase][5]}}, phase_shift[phase]});
      for (int beat = 0; beat < BEATS_PER_PHASE; beat++) begin
        steady <= (phase == 2) && (beat < 120);
        send_random_beat();
      end
      steady <= 1'b0;
    end

    drain();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
